// ===== hdl/capas_pkg.sv =====
// Shared types, constants and helpers for the curvature adaptive point sampler.
// No dependencies; every other file imports this package.
package capas_pkg;

	localparam int MAX_POINTS = 65536;
	localparam int IDX_LIMIT  = (MAX_POINTS < 65536) ? MAX_POINTS : 65536;
	localparam logic [15:0] IDX_LAST = 16'(IDX_LIMIT - 1);

	typedef logic [39:0] acc_t;
	typedef logic [23:0] dist_t;

	localparam acc_t ACC_MAX = '1;

	typedef enum logic [1:0] {
		REG_CURVE_STEP      = 2'd0,
		REG_STRAIGHT_STEP   = 2'd1,
		REG_CURVE_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic               start_req;
		logic signed [19:0] curvature;
		dist_t              step_length;
	} pt_t;

	typedef struct packed {
		logic        sampled;
		logic [15:0] point_index;
	} res_t;

	typedef struct packed {
		dist_t       curve_step;
		dist_t       straight_step;
		logic [18:0] curve_threshold;
	} cfg_t;

	function automatic acc_t sat_add(acc_t a, dist_t b);
		logic [40:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[40] ? ACC_MAX : s[39:0];
	endfunction

endpackage

// ===== hdl/capas_if.sv =====
// Handshake channel interfaces: point input, sample result, register write.
// Depends on capas_pkg for payload types.
interface capas_pt_if;
	import capas_pkg::*;
	logic valid;
	logic ready;
	pt_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface capas_res_if;
	import capas_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface capas_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/curvature_adaptive_point_sampler.sv =====
// A point is held in pt_s1 after acceptance; its result is then registered in res_q.
// Throughput: one point per cycle while the result side does not stall.
// Stalls on the result side hold the input register, which still takes a beat when free.
// Reset (arst_n, asynchronous): accumulators and index cleared, registers to defaults.
// Depends on capas_pkg, capas_if and capas_core.
module curvature_adaptive_point_sampler import capas_pkg::*; (
	input logic clk,
	input logic arst_n,
	capas_pt_if.sink    points,
	capas_res_if.source results,
	capas_cfg_if.sink   cfg
);

	cfg_t cfg_q;
	pt_t  pt_s1;
	logic vld_s1;
	res_t res_q, res_d;
	logic res_vld_q;
	logic adv, fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.curve_step      <= 24'd65536;
			cfg_q.straight_step   <= 24'd262144;
			cfg_q.curve_threshold <= 19'd6554;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CURVE_STEP:      cfg_q.curve_step      <= cfg.data;
				REG_STRAIGHT_STEP:   cfg_q.straight_step   <= cfg.data;
				REG_CURVE_THRESHOLD: cfg_q.curve_threshold <= cfg.data[18:0];
				default: ;
			endcase
		end
	end

	assign adv          = !res_vld_q || results.ready;
	assign fire         = vld_s1 && adv;
	assign points.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (points.ready) begin
			vld_s1 <= points.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (points.ready && points.valid) begin
			pt_s1 <= points.data;
		end
	end

	capas_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.pt     (pt_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign results.valid = res_vld_q;
	assign results.data  = res_q;

`ifndef SYNTHESIS
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!points.ready |-> (vld_s1 && res_vld_q && !results.ready))
		else $error("input stalled without a full pipe");

	a_start_index: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && pt_s1.start_req) |=> (res_q.point_index == 16'd0))
		else $error("start beat did not give index zero");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && !vld_s1) |=> !results.valid)
		else $error("result repeated after its beat");
`endif

endmodule

// ===== hdl/capas_core.sv =====
// Sampler state (distance accumulators, index counter) and the per-point update.
// Depends on capas_pkg.
module capas_core import capas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  pt_t  pt,
	input  cfg_t cfg,
	output res_t res
);

	acc_t        trav_q, next_q, min_q;
	logic [15:0] idx_q;

	acc_t        trav, nt0, mt0, reach, nt1, nt2, mt2;
	logic [15:0] idx, idx_nxt;
	logic [19:0] mag, thr;
	logic        take;

	always_comb begin
		trav = pt.start_req ? '0 : trav_q;
		nt0  = pt.start_req ? '0 : next_q;
		mt0  = pt.start_req ? '0 : min_q;
		idx  = pt.start_req ? '0 : idx_q;
		mag  = pt.curvature[19] ? (~20'(pt.curvature) + 20'd1) : 20'(pt.curvature);
		thr  = {1'b0, cfg.curve_threshold};
		reach = sat_add(trav, pt.step_length);
		nt1  = (reach > mt0 && mag > thr) ? trav : nt0;
		take = reach > nt1;
		nt2  = take ? sat_add(nt1, (mag < thr) ? cfg.straight_step : cfg.curve_step) : nt1;
		mt2  = take ? sat_add(trav, cfg.curve_step) : mt0;
		idx_nxt = (idx == IDX_LAST) ? '0 : idx + 16'd1;
		res.sampled     = take;
		res.point_index = idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trav_q <= '0;
			next_q <= '0;
			min_q  <= '0;
			idx_q  <= '0;
		end else if (en) begin
			trav_q <= reach;
			next_q <= nt2;
			min_q  <= mt2;
			idx_q  <= idx_nxt;
		end
	end

endmodule
